### sv/las_pkg.sv
// ----------------------------------------------------------------------------
// las_pkg
// constants and sequencer states for the longest alternating subsequence block
// ----------------------------------------------------------------------------
package las_pkg;
    localparam int MAX_LEN_DEF    = 64;
    localparam int VALUE_BITS_DEF = 31;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FILL_I,
        ST_FILL_J,
        ST_FILL_WR,
        ST_BEST,
        ST_FIRST,
        ST_WALK_I,
        ST_WALK_J,
        ST_EMIT
    } las_state_t;
endpackage

### sv/las_ram.sv
// ----------------------------------------------------------------------------
// las_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module las_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### sv/longest_alternating_subsequence.sv
// ----------------------------------------------------------------------------
// longest_alternating_subsequence
// loads a sequence and returns its longest strictly alternating subsequence
// ----------------------------------------------------------------------------
// Usage: the input channel (s_valid/s_ready) takes one word per element,
// s_sample_value signed, s_end_of_sequence marking the last. Elements past
// MAX_LEN are dropped and reported by m_overflowed on every result word.
// Loading takes one element per cycle. After the last word the block fills
// its up/down length tables from the back with one shared comparator: for
// element i it reads every later element j once. A best-length scan
// follows, then a walk that emits each chosen value on the output channel
// (m_valid/m_ready) with m_run_end on the last one; the walk scans forward
// through the stored elements and waits on any receiver stall.
// s_ready is low from the last word until the final result is taken. If
// the receiver stalls, the block holds the result word until it is taken.
// aresetn (synchronous, active low) clears the element count, the overflow
// flag and the sequencer; the stores need no clearing since only written
// entries are read.
// ----------------------------------------------------------------------------
module longest_alternating_subsequence
    import las_pkg::*;
#(
    parameter int MAX_LEN    = las_pkg::MAX_LEN_DEF,
    parameter int VALUE_BITS = las_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_sample_value,
    input  logic                         s_end_of_sequence,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VALUE_BITS-1:0] m_chosen_value,
    output logic                         m_run_end,
    output logic                         m_overflowed
);
    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int LW = $clog2(MAX_LEN + 1);

    las_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [LW-1:0] bup_reg, bup_next, bdn_reg, bdn_next;
    logic [LW-1:0] best_reg, best_next;
    logic signed [VALUE_BITS-1:0] vi_reg, vi_next;
    logic [LW-1:0] ui_reg, ui_next, di_reg, di_next;
    logic          mup_reg, mup_next, mdn_reg, mdn_next;
    logic          last_reg, last_next;

    // ram ports
    logic                  v_we, t_we;
    logic [AW-1:0]         v_wa, t_wa, rd_a;
    logic [VALUE_BITS-1:0] v_wd, v_rd;
    logic [LW-1:0]         u_wd, d_wd, u_rd, d_rd;

    las_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LEN)) u_val (
        .aclk(aclk), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
        .rd_addr(rd_a), .rd_data(v_rd));
    las_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_up (
        .aclk(aclk), .wr_en(t_we), .wr_addr(t_wa), .wr_data(u_wd),
        .rd_addr(rd_a), .rd_data(u_rd));
    las_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_dn (
        .aclk(aclk), .wr_en(t_we), .wr_addr(t_wa), .wr_data(d_wd),
        .rd_addr(rd_a), .rd_data(d_rd));

    // shared signed comparator: read word against the held element
    logic gt, lt;
    assign gt = $signed(v_rd) > vi_reg;
    assign lt = $signed(v_rd) < vi_reg;

    logic [CW-1:0] i_ext;
    assign i_ext = CW'(i_reg);

    // the read issued last cycle is at j_reg - 1 during scans
    logic [CW-1:0] jm1;
    assign jm1 = j_reg - CW'(1);

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
        i_reg    <= i_next;
        j_reg    <= j_next;
        bup_reg  <= bup_next;
        bdn_reg  <= bdn_next;
        best_reg <= best_next;
        vi_reg   <= vi_next;
        ui_reg   <= ui_next;
        di_reg   <= di_next;
        mup_reg  <= mup_next;
        mdn_reg  <= mdn_next;
        last_reg <= last_next;
    end

    // sequencer and datapath
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        bup_next   = bup_reg;
        bdn_next   = bdn_reg;
        best_next  = best_reg;
        vi_next    = vi_reg;
        ui_next    = ui_reg;
        di_next    = di_reg;
        mup_next   = mup_reg;
        mdn_next   = mdn_reg;
        last_next  = last_reg;
        v_we = 1'b0;
        v_wa = count_reg[AW-1:0];
        v_wd = s_sample_value;
        t_we = 1'b0;
        t_wa = i_reg;
        u_wd = bup_reg + LW'(1);
        d_wd = bdn_reg + LW'(1);
        rd_a = i_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (count_reg < CW'(MAX_LEN)) begin
                        v_we       = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_end_of_sequence) begin
                        // count is at least one once an item is in
                        i_next     = AW'(((count_reg < CW'(MAX_LEN)) ?
                                          count_reg : count_reg - CW'(1)));
                        state_next = ST_FILL_I;
                    end
                end
            end
            ST_FILL_I: begin
                // read element i
                rd_a       = i_reg;
                bup_next   = '0;
                bdn_next   = '0;
                j_next     = i_ext + CW'(1);
                state_next = ST_FILL_J;
            end
            ST_FILL_J: begin
                // first cycle: data of i; later: data of j-1
                if (j_reg == i_ext + CW'(1)) begin
                    vi_next = v_rd;
                end else begin
                    if (gt && d_rd > bup_reg) bup_next = d_rd;
                    if (lt && u_rd > bdn_reg) bdn_next = u_rd;
                end
                if (j_reg < count_reg) begin
                    rd_a   = j_reg[AW-1:0];
                    j_next = j_reg + CW'(1);
                end else if (j_reg == i_ext + CW'(1)) begin
                    state_next = ST_FILL_WR;
                end else begin
                    j_next     = j_reg + CW'(1);
                    state_next = ST_FILL_WR;
                end
                if (j_reg > count_reg) state_next = ST_FILL_WR;
                if (j_reg == count_reg && j_reg != i_ext + CW'(1)) begin
                    // a spare pass through this state before the table write
                    state_next = ST_FILL_J;
                    j_next     = j_reg + CW'(1);
                end
            end
            ST_FILL_WR: begin
                t_we = 1'b1;
                if (i_reg == '0) begin
                    best_next  = '0;
                    j_next     = '0;
                    state_next = ST_BEST;
                end else begin
                    i_next     = i_reg - AW'(1);
                    state_next = ST_FILL_I;
                end
            end
            ST_BEST: begin
                // stream tables, data of j-1 arrives
                if (j_reg != '0) begin
                    if (u_rd > best_reg) best_next = u_rd;
                    if (d_rd > best_reg && d_rd > u_rd) best_next = d_rd;
                end
                if (j_reg < count_reg) begin
                    rd_a   = j_reg[AW-1:0];
                    j_next = j_reg + CW'(1);
                end else begin
                    j_next     = '0;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: begin
                // find first entry reaching the best length
                if (j_reg != '0 && (u_rd == best_reg || d_rd == best_reg)) begin
                    i_next     = jm1[AW-1:0];
                    state_next = ST_WALK_I;
                    mup_next   = 1'b1;
                    mdn_next   = 1'b1;
                end else begin
                    rd_a   = j_reg[AW-1:0];
                    j_next = j_reg + CW'(1);
                end
            end
            ST_WALK_I: begin
                rd_a       = i_reg;
                j_next     = i_ext + CW'(1);
                state_next = ST_WALK_J;
            end
            ST_WALK_J: begin
                if (j_reg == i_ext + CW'(1)) begin
                    vi_next   = v_rd;
                    ui_next   = u_rd;
                    di_next   = d_rd;
                    last_next = 1'b1;
                    if (best_reg > LW'(1) && j_reg < count_reg) begin
                        rd_a   = j_reg[AW-1:0];
                        j_next = j_reg + CW'(1);
                    end else begin
                        state_next = ST_EMIT;
                    end
                end else if (mup_reg && ui_reg == best_reg && gt &&
                             d_rd == best_reg - LW'(1)) begin
                    last_next  = 1'b0;
                    j_next     = jm1;
                    mup_next   = 1'b0;
                    mdn_next   = 1'b1;
                    state_next = ST_EMIT;
                end else if (mdn_reg && di_reg == best_reg && lt &&
                             u_rd == best_reg - LW'(1)) begin
                    last_next  = 1'b0;
                    j_next     = jm1;
                    mup_next   = 1'b1;
                    mdn_next   = 1'b0;
                    state_next = ST_EMIT;
                end else if (j_reg < count_reg) begin
                    rd_a   = j_reg[AW-1:0];
                    j_next = j_reg + CW'(1);
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (last_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        i_next     = j_reg[AW-1:0];
                        best_next  = best_reg - LW'(1);
                        state_next = ST_WALK_I;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        s_ready        = (state_reg == ST_LOAD);
        m_valid        = (state_reg == ST_EMIT);
        m_chosen_value = vi_reg;
        m_run_end      = last_reg;
        m_overflowed   = ovf_reg;
    end
endmodule
